### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a single clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge while reset is low.
`define GLU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never hold, checked outside reset.
`define GLU_ASSERT_NEVER(label, clk, rst, cond) \
  `GLU_ASSERT(label, clk, rst, !(cond))

`endif

### rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// GCD and LCM unit package
// Widths and transfer types shared by the unit and its checker.
// ----------------------------------------------------------------------------
package glu_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int PRODUCT_BITS = 2 * OPERAND_BITS;
  localparam int CNT_BITS     = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [PRODUCT_BITS-1:0] product_t;

  typedef struct packed {
    operand_t first_operand;
    operand_t second_operand;
  } operand_pair_t;

  typedef struct packed {
    operand_t common_divisor;
    product_t common_multiple;
  } result_t;

endpackage

### rtl/gcd_lcm_unit_top.sv
// ----------------------------------------------------------------------------
// GCD and LCM unit
// Greatest common divisor and least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
// A transfer is taken at a rising edge where start is high and busy is low.
// The operand pair is sampled then; for nonzero operands, busy stays high
// until the result is ready. The result appears on the result port for
// exactly one cycle, marked by done; the receiver cannot stall it and must
// take it then. If either operand is zero, done is high in the cycle after
// the transfer. Otherwise the unit strips common factors of two, runs a
// binary GCD loop (one shift, swap or subtract per cycle), divides the first
// operand by the divisor and multiplies the quotient by the second operand.
// The operand values set the length of the first two phases, and only one
// pair is in flight at a time.
// Busy drops in the cycle done is high, so a new transfer may be taken
// while the previous result is shown. Synchronous reset returns the unit
// to idle and clears done; no result is in flight afterward.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_top
  import glu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  operand_pair_t operands,
  output logic          done,
  output result_t       result
);

  localparam int ALU_BITS = PRODUCT_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_GCD,
    ST_DIV,
    ST_MUL
  } state_t;

  state_t                state;
  operand_t              u;
  operand_t              v;
  operand_t              g;
  operand_t              q;
  operand_t              rem;
  operand_t              b_keep;
  logic [CNT_BITS-1:0]   k;
  logic [CNT_BITS-1:0]   cnt;
  product_t              acc;
  product_t              mcand;

  logic [ALU_BITS-1:0]   alu_a;
  logic [ALU_BITS-1:0]   alu_b;
  logic                  alu_sub;
  logic [ALU_BITS-1:0]   alu_sum;
  logic                  borrow;
  logic                  last_iter;

  assign busy = (state != ST_IDLE);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_GCD: begin
        alu_a   = ALU_BITS'(u);
        alu_b   = ALU_BITS'(v);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = ALU_BITS'({rem, q[OPERAND_BITS-1]});
        alu_b   = ALU_BITS'(g);
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a   = ALU_BITS'(acc);
        alu_b   = ALU_BITS'(mcand);
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_BITS'(alu_sub);
  assign borrow    = alu_sum[ALU_BITS-1];
  assign last_iter = (cnt == CNT_BITS'(OPERAND_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && ((operands.first_operand == '0) ||
                        (operands.second_operand == '0))) begin
            result.common_divisor  <= operands.first_operand | operands.second_operand;
            result.common_multiple <= '0;
            done                   <= 1'b1;
          end else if (start) begin
            done   <= 1'b0;
            u      <= operands.first_operand;
            v      <= operands.second_operand;
            q      <= operands.first_operand;
            b_keep <= operands.second_operand;
            k      <= '0;
            state  <= ST_TWOS;
          end else begin
            done <= 1'b0;
          end
        end
        ST_TWOS: begin
          done <= 1'b0;
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 1'b1;
          end else begin
            state <= ST_GCD;
          end
        end
        ST_GCD: begin
          done <= 1'b0;
          if (u == v) begin
            g     <= u << k;
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (!borrow) begin
            u <= alu_sum[OPERAND_BITS-1:0];
          end else begin
            u <= v;
            v <= u;
          end
        end
        ST_DIV: begin
          done <= 1'b0;
          if (!borrow) begin
            rem <= alu_sum[OPERAND_BITS-1:0];
            q   <= {q[OPERAND_BITS-2:0], 1'b1};
          end else begin
            rem <= {rem[OPERAND_BITS-2:0], q[OPERAND_BITS-1]};
            q   <= {q[OPERAND_BITS-2:0], 1'b0};
          end
          if (last_iter) begin
            cnt   <= '0;
            acc   <= '0;
            mcand <= PRODUCT_BITS'(b_keep);
            state <= ST_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_MUL: begin
          if (q[0]) begin
            acc <= alu_sum[PRODUCT_BITS-1:0];
          end
          q     <= q >> 1;
          mcand <= mcand << 1;
          cnt   <= cnt + 1'b1;
          done  <= last_iter;
          if (last_iter) begin
            result.common_divisor  <= g;
            result.common_multiple <= q[0] ? alu_sum[PRODUCT_BITS-1:0] : acc;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/glu_checker.sv
// ----------------------------------------------------------------------------
// GCD and LCM unit checker
// Port-level assertions on transfer sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glu_checker
  import glu_pkg::*;
(
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input operand_pair_t operands,
  input logic          done,
  input result_t       result
);

  logic accept;
  logic zero_in;

  assign accept  = start && !busy;
  assign zero_in = (operands.first_operand == '0) || (operands.second_operand == '0);

  `GLU_ASSERT(a_accept_progress, clk, rst, accept |=> (busy || done))
  `GLU_ASSERT(a_single_strobe, clk, rst, (done && !accept) |=> !done)
  `GLU_ASSERT_NEVER(a_done_while_busy, clk, rst, done && busy)
  `GLU_ASSERT(a_zero_fast_path, clk, rst, (accept && zero_in) |=> (done && !busy))
  `GLU_ASSERT(a_zero_divisor, clk, rst,
    (done && (result.common_divisor == '0)) |-> (result.common_multiple == '0))

endmodule

bind gcd_lcm_unit_top glu_checker u_glu_checker (.*);
